// ===== sv/qs_pkg.sv =====
// ----------------------------------------------------------------------------
// qs_pkg: shared types and constants of the quaternion slerp unit
// Fixed-point formats, stage payload structs and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package qs_pkg;

  // Input and output components carry this many fraction bits
  localparam int FRAC_BITS  = 14;
  // Angles, sines and weights are Q30
  localparam int ANGLE_BITS = 30;
  // One in the blend factor format
  localparam logic [14:0] ONE = 15'(1 << FRAC_BITS);
  // Square root steps: one result bit per step for a 61-bit radicand
  localparam int ROOT_STEPS = 31;
  // Quotient bits produced by the weight divider
  localparam int DIV_STEPS  = 34;

  // Item fields after capture, t saturated to one; index 0..3 is x, y, z, w
  typedef struct packed {
    logic [3:0][15:0] q0;
    logic [3:0][15:0] q1;
    logic [14:0]      t;
  } raw_t;

  // Fields that ride along every stage after the dot product
  typedef struct packed {
    logic [3:0][16:0] q0;   // first quaternion, sign-corrected
    logic [3:0][15:0] q1;
    logic [14:0]      t;
    logic             lin;  // linear blend selected
  } side_t;

  // Square root stage payload
  typedef struct packed {
    logic [30:0] d;   // clamped dot in Q30
    logic [60:0] n;   // radicand remainder
    logic [61:0] r;   // partial root
    side_t       side;
  } root_t;

  // Vectoring CORDIC stage payload
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    side_t              side;
  } vec_t;

  // Rotation CORDIC stage payload: lane 0 theta, 1 (1-t)theta, 2 t*theta
  typedef struct packed {
    logic [2:0][51:0] a;
    logic [2:0][33:0] x;
    logic [2:0][33:0] y;
    side_t            side;
  } sn_t;

  // Sines leaving the rotation CORDIC
  typedef struct packed {
    logic [2:0][33:0] s;
    side_t            side;
  } sine_t;

  // Divider stage payload, two lanes
  typedef struct packed {
    logic [1:0][31:0] rem;
    logic [1:0][33:0] q;
    logic [1:0][31:0] mag;
    logic [1:0]       neg;
    logic [1:0]       ovf;
    logic [31:0]      den;
    logic             fb;   // sine of theta not positive
    side_t            side;
  } dv_t;

  // Final weights
  typedef struct packed {
    logic [1:0][34:0] w;
    side_t            side;
  } wt_t;

  // floor(atan(2^-k) * 2^30)
  function automatic logic [29:0] atan_at(input logic [4:0] k);
    logic [29:0] v;
    case (k)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qs_front.sv =====
// ----------------------------------------------------------------------------
// qs_front: capture, dot product and radicand
// Four stages: capture, products, dot sum with sign fix, 1 - d^2.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  qs_pkg::raw_t      raw_i,
  input  wire  [14:0]       thr_i,
  output logic              valid_o,
  output qs_pkg::root_t     root_o
);

  typedef struct packed {
    logic [3:0][31:0] p;
    qs_pkg::raw_t     raw;
  } prod_t;

  typedef struct packed {
    logic [30:0]     d;
    qs_pkg::side_t   side;
  } dot_t;

  qs_pkg::raw_t  a_d, a_q;
  prod_t         b_d, b_q;
  dot_t          c_d, c_q;
  qs_pkg::root_t d_d, d_q;
  logic [3:0]    vld_q;

  // Capture and saturate t to one
  always_comb begin
    a_d = raw_i;
    if (raw_i.t > qs_pkg::ONE) begin
      a_d.t = qs_pkg::ONE;
    end
  end

  // Form the four products
  always_comb begin
    logic signed [31:0] pr;
    b_d.raw = a_q;
    for (int j = 0; j < 4; j++) begin
      pr = $signed(a_q.q0[j]) * $signed(a_q.q1[j]);
      b_d.p[j] = pr;
    end
  end

  // Sum, fold the sign into q0, pick the path, clamp d to one
  always_comb begin
    logic signed [33:0] dot;
    logic [33:0]        mag;
    logic [34:0]        dw;
    dot = '0;
    for (int j = 0; j < 4; j++) begin
      dot = dot + 34'($signed(b_q.p[j]));
    end
    mag = dot[33] ? 34'(-dot) : 34'(dot);
    for (int j = 0; j < 4; j++) begin
      c_d.side.q0[j] = dot[33] ? -17'($signed(b_q.raw.q0[j])) :
                                 17'($signed(b_q.raw.q0[j]));
      c_d.side.q1[j] = b_q.raw.q1[j];
    end
    c_d.side.t   = b_q.raw.t;
    c_d.side.lin = mag[32:0] >= {4'd0, thr_i, 14'd0};
    dw = {mag[32:0], 2'b00};
    c_d.d = (dw > 35'(1 << qs_pkg::ANGLE_BITS)) ? 31'(1 << qs_pkg::ANGLE_BITS) : dw[30:0];
  end

  // Radicand 1 - d^2 in Q60
  always_comb begin
    logic [61:0] sq;
    sq     = {31'd0, c_q.d} * {31'd0, c_q.d};
    d_d.d  = c_q.d;
    d_d.n  = (61'(1) << 60) - sq[60:0];
    d_d.r  = '0;
    d_d.side = c_q.side;
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign root_o  = d_q;

endmodule

`default_nettype wire

// ===== sv/qs_isqrt.sv =====
// ----------------------------------------------------------------------------
// qs_isqrt: pipelined integer square root
// One root bit per stage, restoring form, 31 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_isqrt (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  qs_pkg::root_t     root_i,
  output logic              valid_o,
  output qs_pkg::root_t     root_o
);

  localparam int Steps = qs_pkg::ROOT_STEPS;

  qs_pkg::root_t      pipe_q [Steps];
  logic [Steps-1:0]   vld_q;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    qs_pkg::root_t src, nxt;
    if (i == 0) begin : g_first
      assign src = root_i;
    end else begin : g_rest
      assign src = pipe_q[i-1];
    end

    // Try the next root bit
    always_comb begin
      logic [61:0] bit_v;
      logic [61:0] trial;
      nxt   = src;
      bit_v = 62'(1) << (60 - 2 * i);
      trial = src.r + bit_v;
      if ({1'b0, src.n} >= trial) begin
        nxt.n = src.n - trial[60:0];
        nxt.r = (src.r >> 1) + bit_v;
      end else begin
        nxt.r = src.r >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pipe_q[i] <= nxt;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = pipe_q[Steps-1];

endmodule

`default_nettype wire

// ===== sv/qs_vector.sv =====
// ----------------------------------------------------------------------------
// qs_vector: vectoring CORDIC for theta = acos(d)
// Rotates (d, sqrt(1 - d^2)) onto the x axis, one iteration per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_vector #(
  parameter int Steps = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  qs_pkg::root_t     root_i,
  output logic              valid_o,
  output qs_pkg::vec_t      vec_o
);

  qs_pkg::vec_t       init;
  qs_pkg::vec_t       pipe_q [Steps];
  logic [Steps:0]     vld;
  logic [Steps-1:0]   vld_q;

  // Start vector: x = d, y = root
  always_comb begin
    init.x    = {3'd0, root_i.d};
    init.y    = {3'd0, root_i.r[30:0]};
    init.z    = '0;
    init.side = root_i.side;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam int K = i % 32;
    qs_pkg::vec_t src, nxt;
    if (i == 0) begin : g_first
      assign src = init;
    end else begin : g_rest
      assign src = pipe_q[i-1];
    end

    // Drive y toward zero, accumulate the angle
    always_comb begin
      logic signed [33:0] at;
      nxt = src;
      at  = {4'd0, qs_pkg::atan_at(5'(K))};
      if (!src.y[33]) begin
        nxt.x = src.x + (src.y >>> K);
        nxt.y = src.y - (src.x >>> K);
        nxt.z = src.z + at;
      end else begin
        nxt.x = src.x - (src.y >>> K);
        nxt.y = src.y + (src.x >>> K);
        nxt.z = src.z - at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pipe_q[i] <= nxt;
      end
    end
  end

  assign vld = {vld_q, valid_i};

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld[Steps-1:0];
    end
  end

  assign valid_o = vld[Steps];
  assign vec_o   = pipe_q[Steps-1];

endmodule

`default_nettype wire

// ===== sv/qs_sine.sv =====
// ----------------------------------------------------------------------------
// qs_sine: three-lane rotation CORDIC
// Scales theta by (1-t) and t, then finds the three sines in lockstep.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_sine #(
  parameter int Steps = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  qs_pkg::vec_t      vec_i,
  output logic              valid_o,
  output qs_pkg::sine_t     sine_o
);

  qs_pkg::sn_t        pro_d, pro_q;
  qs_pkg::sn_t        pipe_q [Steps];
  logic [Steps:0]     vld_q;

  // Scale theta; the products wrap like unsigned 64-bit values
  always_comb begin
    logic signed [33:0] theta;
    logic signed [49:0] p1, p2;
    logic [63:0]        e1, e2;
    logic [14:0]        omt;
    logic signed [51:0] a0;
    theta = vec_i.z;
    omt   = qs_pkg::ONE - vec_i.side.t;
    p1    = $signed({1'b0, omt}) * theta;
    p2    = $signed({1'b0, vec_i.side.t}) * theta;
    e1    = {{14{p1[49]}}, p1};
    e2    = {{14{p2[49]}}, p2};
    a0    = theta;
    pro_d.a[0] = a0;
    pro_d.a[1] = {2'b00, e1[63:qs_pkg::FRAC_BITS]};
    pro_d.a[2] = {2'b00, e2[63:qs_pkg::FRAC_BITS]};
    for (int l = 0; l < 3; l++) begin
      pro_d.x[l] = 34'(1 << qs_pkg::ANGLE_BITS);
      pro_d.y[l] = '0;
    end
    pro_d.side = vec_i.side;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam int K = i % 32;
    qs_pkg::sn_t src, nxt;
    if (i == 0) begin : g_first
      assign src = pro_q;
    end else begin : g_rest
      assign src = pipe_q[i-1];
    end

    // Rotate each lane toward its residual angle
    always_comb begin
      logic signed [51:0] at;
      logic signed [33:0] sx, sy;
      nxt = src;
      at  = {22'd0, qs_pkg::atan_at(5'(K))};
      for (int l = 0; l < 3; l++) begin
        sx = $signed(src.x[l]);
        sy = $signed(src.y[l]);
        if (!src.a[l][51]) begin
          nxt.x[l] = sx - (sy >>> K);
          nxt.y[l] = sy + (sx >>> K);
          nxt.a[l] = $signed(src.a[l]) - at;
        end else begin
          nxt.x[l] = sx + (sy >>> K);
          nxt.y[l] = sy - (sx >>> K);
          nxt.a[l] = $signed(src.a[l]) + at;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pipe_q[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pro_q <= pro_d;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], valid_i};
    end
  end

  assign valid_o     = vld_q[Steps];
  assign sine_o.s    = pipe_q[Steps-1].y;
  assign sine_o.side = pipe_q[Steps-1].side;

endmodule

`default_nettype wire

// ===== sv/qs_divide.sv =====
// ----------------------------------------------------------------------------
// qs_divide: two-lane weight divider
// Restoring division sin(a)/sin(theta) in Q30, one quotient bit per stage,
// then saturation to four and the linear weight fallback.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_divide (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  qs_pkg::sine_t     sine_i,
  output logic              valid_o,
  output qs_pkg::wt_t       wt_o
);

  localparam int Steps = qs_pkg::DIV_STEPS;

  qs_pkg::dv_t        pro_d, pro_q;
  qs_pkg::dv_t        pipe_q [Steps];
  qs_pkg::wt_t        wt_d, wt_q;
  logic [Steps+1:0]   vld_q;

  // Split signs, flag a quotient of 2^34 or more
  always_comb begin
    logic signed [33:0] sv;
    logic [33:0]        av;
    pro_d.den  = sine_i.s[0][31:0];
    pro_d.fb   = sine_i.s[0][33] || (sine_i.s[0] == '0);
    pro_d.side = sine_i.side;
    for (int l = 0; l < 2; l++) begin
      sv = $signed(sine_i.s[l+1]);
      av = sv[33] ? 34'(-sv) : 34'(sv);
      pro_d.neg[l] = sv[33];
      pro_d.mag[l] = av[31:0];
      pro_d.ovf[l] = {4'd0, av[31:0]} >= {pro_d.den, 4'd0};
      pro_d.rem[l] = {4'd0, av[31:4]};
      pro_d.q[l]   = '0;
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int B = Steps - 1 - j;
    qs_pkg::dv_t src, nxt;
    if (j == 0) begin : g_first
      assign src = pro_q;
    end else begin : g_rest
      assign src = pipe_q[j-1];
    end

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
      logic [61:0] num;
      logic [32:0] sh;
      nxt = src;
      for (int l = 0; l < 2; l++) begin
        num = {src.mag[l], 30'd0};
        sh  = {src.rem[l], num[B]};
        if (sh >= {1'b0, src.den}) begin
          nxt.rem[l]  = 32'(sh - {1'b0, src.den});
          nxt.q[l][B] = 1'b1;
        end else begin
          nxt.rem[l]  = sh[31:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pipe_q[j] <= nxt;
      end
    end
  end

  // Saturate, restore signs, or fall back to the linear weights
  always_comb begin
    qs_pkg::dv_t        fin;
    logic [32:0]        m;
    logic [14:0]        omt;
    fin       = pipe_q[Steps-1];
    wt_d.side = fin.side;
    omt       = qs_pkg::ONE - fin.side.t;
    for (int l = 0; l < 2; l++) begin
      if (fin.ovf[l] || (fin.q[l] > 34'(64'd1 << 32))) begin
        m = 33'(64'd1 << 32);
      end else begin
        m = fin.q[l][32:0];
      end
      wt_d.w[l] = fin.neg[l] ? 35'(-{2'b00, m}) : {2'b00, m};
    end
    if (fin.fb || fin.side.lin) begin
      wt_d.w[0] = {4'd0, omt, 16'd0};
      wt_d.w[1] = {4'd0, fin.side.t, 16'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pro_q <= pro_d;
      wt_q  <= wt_d;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps:0], valid_i};
    end
  end

  assign valid_o = vld_q[Steps+1];
  assign wt_o    = wt_q;

endmodule

`default_nettype wire

// ===== sv/qs_blend.sv =====
// ----------------------------------------------------------------------------
// qs_blend: weighted sum and output register
// Multiplies each component by its weight, rounds, saturates, holds result.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_blend (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  qs_pkg::wt_t               wt_i,
  output logic                      valid_o,
  output logic [3:0][15:0]          res_o,
  output logic                      lin_o
);

  typedef struct packed {
    logic [3:0][51:0] p0;
    logic [3:0][51:0] p1;
    logic             lin;
  } prod_t;

  prod_t            p_d, p_q;
  logic             p_vld_q;
  logic [3:0][15:0] res_d, res_q;
  logic             lin_q;
  logic             out_vld_q;

  // Form the eight products
  always_comb begin
    logic signed [51:0] a, b;
    for (int j = 0; j < 4; j++) begin
      a = $signed(wt_i.side.q0[j]) * $signed(wt_i.w[0]);
      b = $signed(wt_i.side.q1[j]) * $signed(wt_i.w[1]);
      p_d.p0[j] = a;
      p_d.p1[j] = b;
    end
    p_d.lin = wt_i.side.lin;
  end

  // Sum, round half up, saturate
  always_comb begin
    logic signed [52:0] s;
    logic signed [22:0] r;
    for (int j = 0; j < 4; j++) begin
      s = 53'($signed(p_q.p0[j])) + 53'($signed(p_q.p1[j])) +
          53'(64'd1 << (qs_pkg::ANGLE_BITS - 1));
      r = s[52:qs_pkg::ANGLE_BITS];
      if (r > 23'sd32767) begin
        res_d[j] = 16'h7fff;
      end else if (r < -23'sd32768) begin
        res_d[j] = 16'h8000;
      end else begin
        res_d[j] = r[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      res_q <= res_d;
      lin_q <= p_q.lin;
    end
  end

  // Advance valid bits; the last one marks a result waiting for transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q   <= valid_i;
      out_vld_q <= p_vld_q;
    end
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;
  assign lin_o   = lin_q;

endmodule

`default_nettype wire

// ===== sv/quaternion_slerp_unit.sv =====
// The unit returns one result per item, in order. The pipeline holds the
// capture and dot product stages, 31 square root stages, CORDIC_STEPS
// vectoring stages, 1 + CORDIC_STEPS rotation stages, 36 divider stages and
// 2 blend stages. The whole pipeline stalls as one when a result waits for
// transfer, so the unit takes one item per cycle while out_ready_i stays high.
// linear_threshold resets to 16383 and is written through the cfg channel,
// which is always ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
// quaternion_slerp_unit: pipelined fixed-point quaternion slerp
// Dot product, acos by CORDIC, three sines, two divides and the blend.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  [14:0]       cfg_linear_threshold_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [15:0]       first_x_i,
  input  wire  [15:0]       first_y_i,
  input  wire  [15:0]       first_z_i,
  input  wire  [15:0]       first_w_i,
  input  wire  [15:0]       second_x_i,
  input  wire  [15:0]       second_y_i,
  input  wire  [15:0]       second_z_i,
  input  wire  [15:0]       second_w_i,
  input  wire  [14:0]       blend_factor_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [15:0]       out_x_o,
  output logic [15:0]       out_y_o,
  output logic [15:0]       out_z_o,
  output logic [15:0]       out_w_o,
  output logic              took_linear_path_o
);

  logic [14:0]      thr_q;
  logic             en;
  qs_pkg::raw_t     raw;
  logic             f_vld, r_vld, v_vld, s_vld, d_vld;
  qs_pkg::root_t    f_root, r_root;
  qs_pkg::vec_t     v_out;
  qs_pkg::sine_t    s_out;
  qs_pkg::wt_t      d_out;
  logic [3:0][15:0] res;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd16383;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_linear_threshold_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Advance the pipeline unless a result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    raw.q0[0] = first_x_i;
    raw.q0[1] = first_y_i;
    raw.q0[2] = first_z_i;
    raw.q0[3] = first_w_i;
    raw.q1[0] = second_x_i;
    raw.q1[1] = second_y_i;
    raw.q1[2] = second_z_i;
    raw.q1[3] = second_w_i;
    raw.t     = blend_factor_i;
  end

  qs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .raw_i   (raw),
    .thr_i   (thr_q),
    .valid_o (f_vld),
    .root_o  (f_root)
  );

  qs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .root_i  (f_root),
    .valid_o (r_vld),
    .root_o  (r_root)
  );

  qs_vector #(.Steps(CORDIC_STEPS)) u_vector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_vld),
    .root_i  (r_root),
    .valid_o (v_vld),
    .vec_o   (v_out)
  );

  qs_sine #(.Steps(CORDIC_STEPS)) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_vld),
    .vec_i   (v_out),
    .valid_o (s_vld),
    .sine_o  (s_out)
  );

  qs_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_vld),
    .sine_i  (s_out),
    .valid_o (d_vld),
    .wt_o    (d_out)
  );

  qs_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld),
    .wt_i    (d_out),
    .valid_o (out_valid_o),
    .res_o   (res),
    .lin_o   (took_linear_path_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];
  assign out_w_o = res[3];

endmodule

`default_nettype wire

// ===== sv/qs_checker.sv =====
// ----------------------------------------------------------------------------
// qs_checker: port-level checks for the quaternion slerp unit
// Stall coupling, result hold, reset and configuration readiness.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        cfg_valid_i,
  input wire        cfg_ready_o,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [15:0] out_x_o,
  input wire [15:0] out_y_o,
  input wire [15:0] out_z_o,
  input wire [15:0] out_w_o,
  input wire        took_linear_path_o
);

  // Input side stalls exactly when a held result is not taken
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready does not follow output stall");

  // A result waiting for transfer holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) &&
    $stable(out_y_o) && $stable(out_z_o) && $stable(out_w_o) &&
    $stable(took_linear_path_o))
    else $error("held result changed");

  // No result right after reset releases
  a_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !out_valid_o)
    else $error("result present after reset");

  // Threshold writes are never stalled
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind quaternion_slerp_unit qs_checker u_qs_checker (.*);

`default_nettype wire

// ===== tb/quaternion_slerp_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_slerp_unit_test: self-checking bench for the slerp unit
// Drives quaternion pairs in bursts, stalls the result side, predicts every
// blend in fixed point and checks each transfer against the oldest prediction.
// ----------------------------------------------------------------------------

// One blend input as it crosses the input channel
typedef struct packed {
  logic [3:0][15:0] a;   // first quaternion x, y, z, w
  logic [3:0][15:0] b;   // second quaternion x, y, z, w
  logic [14:0]      t;
} slerp_item_t;

// One blended quaternion with its path flag
typedef struct packed {
  logic [3:0][15:0] q;
  logic             lin;
} blend_result_t;

class blend_scoreboard;
  localparam int FRAC    = 14;
  localparam int ABITS   = 30;
  localparam int STEPS   = 16;
  localparam longint ONE = 64'sd1 << FRAC;

  longint        angle_lut[32];
  logic [14:0]   threshold;
  blend_result_t pending_blends[$];
  int            errors;

  function new();
    angle_lut = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                  16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                  131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                  127, 63, 31, 15, 7, 3, 1, 0, 0};
    threshold = 15'd16383;
    errors    = 0;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  static function longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Vectoring pass: angle of (x, y) in Q30
  function longint vector_angle(longint x, longint y);
    longint z, nx;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> (i & 31));
        y  = y - (x >>> (i & 31));
        z += angle_lut[i & 31];
      end else begin
        nx = x - (y >>> (i & 31));
        y  = y + (x >>> (i & 31));
        z -= angle_lut[i & 31];
      end
      x = nx;
    end
    return z;
  endfunction

  // Rotation pass: uncompensated sine of a Q30 angle
  function longint rotate_sine(longint ang);
    longint x, y, nx;
    x = 64'sd1 << ABITS;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (ang >= 0) begin
        nx = x - (y >>> (i & 31));
        y  = y + (x >>> (i & 31));
        ang -= angle_lut[i & 31];
      end else begin
        nx = x + (y >>> (i & 31));
        y  = y - (x >>> (i & 31));
        ang += angle_lut[i & 31];
      end
      x = nx;
    end
    return y;
  endfunction

  static function longint weight_quotient(longint num, longint den);
    longint unsigned mag, q;
    longint w;
    mag = (num < 0) ? -num : num;
    q = (mag << ABITS) / longint'(den);
    w = (q > (64'd1 << 32)) ? (64'sd1 << 32) : longint'(q);
    return (num < 0) ? -w : w;
  endfunction

  function blend_result_t predict_blend(slerp_item_t it);
    blend_result_t r;
    longint q0[4], q1[4], t, dot, d, theta, sin_t, s0, s1, w0, w1, s;
    longint unsigned dd;
    t = it.t;
    if (t > ONE) t = ONE;
    dot = 0;
    for (int j = 0; j < 4; j++) begin
      q0[j] = longint'($signed(it.a[j]));
      q1[j] = longint'($signed(it.b[j]));
      dot += q0[j] * q1[j];
    end
    // Take the short way round
    if (dot < 0) begin
      dot = -dot;
      for (int j = 0; j < 4; j++) q0[j] = -q0[j];
    end
    r.lin = (dot >= (longint'(threshold) << FRAC));
    if (r.lin) begin
      for (int j = 0; j < 4; j++) begin
        s = q0[j] * (ONE - t) + q1[j] * t + (ONE >> 1);
        r.q[j] = 16'(clip16(s >>> FRAC));
      end
    end else begin
      d = dot << (ABITS - 2 * FRAC);
      if (d > (64'sd1 << ABITS)) d = 64'sd1 << ABITS;
      dd = (64'd1 << (2 * ABITS)) - longint'(d * d);
      theta = vector_angle(d, longint'(int_sqrt(dd)));
      sin_t = rotate_sine(theta);
      s0 = rotate_sine(longint'((longint'(ONE - t) * theta) >> FRAC));
      s1 = rotate_sine(longint'((longint'(t) * theta) >> FRAC));
      // Sine not positive: fall back to linear weights, flag stays low
      if (sin_t > 0) begin
        w0 = weight_quotient(s0, sin_t);
        w1 = weight_quotient(s1, sin_t);
      end else begin
        w0 = (ONE - t) << (ABITS - FRAC);
        w1 = t << (ABITS - FRAC);
      end
      for (int j = 0; j < 4; j++) begin
        s = q0[j] * w0 + q1[j] * w1 + (64'sd1 << (ABITS - 1));
        r.q[j] = 16'(clip16(s >>> ABITS));
      end
    end
    return r;
  endfunction

  function void note_input(slerp_item_t it);
    pending_blends.push_back(predict_blend(it));
  endfunction

  function void check_result(blend_result_t got);
    blend_result_t exp_r;
    string names[4];
    names = '{"out_x", "out_y", "out_z", "out_w"};
    if (pending_blends.size() == 0) begin
      $error("result transfer with no blend outstanding");
      errors++;
      return;
    end
    exp_r = pending_blends.pop_front();
    for (int j = 0; j < 4; j++) begin
      if (got.q[j] !== exp_r.q[j]) begin
        $error("%s expected %0d actual %0d", names[j], $signed(exp_r.q[j]),
               $signed(got.q[j]));
        errors++;
      end
    end
    if (got.lin !== exp_r.lin) begin
      $error("took_linear_path expected %0d actual %0d", exp_r.lin, got.lin);
      errors++;
    end
  endfunction

  function int outstanding();
    return pending_blends.size();
  endfunction
endclass

module quaternion_slerp_unit_test;
  localparam int LATENCY     = 106;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [14:0] cfg_linear_threshold_i;
  logic        in_valid_i, in_ready_o;
  logic [15:0] first_x_i, first_y_i, first_z_i, first_w_i;
  logic [15:0] second_x_i, second_y_i, second_z_i, second_w_i;
  logic [14:0] blend_factor_i;
  logic        out_valid_o, out_ready_i;
  logic [15:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic        took_linear_path_o;

  blend_scoreboard sb = new();
  bit          hold_req;
  int          idle_cycles;

  quaternion_slerp_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_linear_threshold_i,
    .in_valid_i, .in_ready_o,
    .first_x_i, .first_y_i, .first_z_i, .first_w_i,
    .second_x_i, .second_y_i, .second_z_i, .second_w_i,
    .blend_factor_i,
    .out_valid_o, .out_ready_i,
    .out_x_o, .out_y_o, .out_z_o, .out_w_o, .took_linear_path_o
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{q: {out_w_o, out_z_o, out_y_o, out_x_o},
                        lin: took_linear_path_o});
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: stall on a changing pattern, or hold off on request
  initial begin
    int mode;
    int tick;
    out_ready_i = 1'b0;
    mode = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (tick % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = ($urandom_range(0, 3) != 0);
          2: out_ready_i = ($urandom_range(0, 3) == 0);
          default: out_ready_i = (tick % 8 != 0);
        endcase
      end
      tick++;
    end
  end

  // Offer one item and hold it until transfer
  task automatic send_item(slerp_item_t it);
    @(negedge clk_i);
    {first_w_i, first_z_i, first_y_i, first_x_i}     = it.a;
    {second_w_i, second_z_i, second_y_i, second_x_i} = it.b;
    blend_factor_i = it.t;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
  endtask

  task automatic drop_valid(int cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Wait for every blend to come back, then let the pipeline settle
  task automatic drain();
    drop_valid(0);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [14:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_linear_threshold_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.threshold = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [14:0] pick_blend();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? 15'd0 : 15'd16384;
      1: return 15'($urandom_range(0, 32767));
      default: return 15'($urandom_range(0, 16384));
    endcase
  endfunction

  // Roughly unit quaternion pair, close together, random hemisphere
  function automatic slerp_item_t pick_unit_pair();
    slerp_item_t it;
    longint c[4], sum, spread, lim;
    lim = $urandom_range(0, 1) ? 8000 : 600;
    sum = 0;
    for (int j = 0; j < 3; j++) begin
      c[j] = longint'($urandom_range(0, 32'(2 * lim))) - lim;
      sum += c[j] * c[j];
    end
    c[3] = longint'(sb.int_sqrt((64'd1 << 28) - sum));
    if ($urandom_range(0, 1)) c[3] = -c[3];
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 4;
      2: spread = 64;
      default: spread = 1024;
    endcase
    for (int j = 0; j < 4; j++) begin
      it.a[j] = 16'(c[j]);
      it.b[j] = 16'(sb.clip16(c[j] + longint'($urandom_range(0, 32'(2 * spread)))
                              - spread));
    end
    if ($urandom_range(0, 1)) for (int j = 0; j < 4; j++) it.b[j] = -it.b[j];
    it.t = pick_blend();
    return it;
  endfunction

  function automatic slerp_item_t pick_item();
    slerp_item_t it;
    if ($urandom_range(0, 9) < 7) return pick_unit_pair();
    it.a = {$urandom(), $urandom()};
    it.b = {$urandom(), $urandom()};
    it.t = pick_blend();
    return it;
  endfunction

  task automatic run_directed();
    slerp_item_t it;
    logic [15:0] vals[6];
    vals = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h0001};
    // identity to w-only targets (zero, identity, its negation, extremes) and to an orthogonal axis
    it.a = {16'h4000, 16'h0, 16'h0, 16'h0};
    foreach (vals[k]) begin
      it.b = {vals[k], 16'h0, 16'h0, 16'h0};
      it.t = 15'd8192;
      send_item(it);
    end
    it.b = {16'h0, 16'h0, 16'h0, 16'h4000};
    it.t = 15'd16384;
    send_item(it);
    // full-scale components, both signs
    it.a = {4{16'h7FFF}};
    it.b = {4{16'h8000}};
    foreach (vals[k]) begin
      it.t = (k % 2) ? 15'd32767 : 15'd0;
      send_item(it);
    end
    it.b = {4{16'h7FFF}};
    send_item(it);
    it.a = {4{16'h8000}};
    it.b = {4{16'h8000}};
    send_item(it);
    // equal inputs, then near-equal ones, over the range of t, then all zeros
    it.a = {16'h2D41, 16'h2D41, 16'h0, 16'h0};
    it.b = it.a;
    it.t = 15'd16385;
    send_item(it);
    it.b = {16'h2D40, 16'h2D42, 16'h0003, 16'h0};
    it.t = 15'd1;
    send_item(it);
    it.t = 15'd16383;
    send_item(it);
    it.a = '0;
    it.b = '0;
    send_item(it);
  endtask

  task automatic run_random(int count, bit steady, bit with_hold, bit with_pause);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_item(pick_item());
        sent++;
        if (with_hold && sent == count / 4) hold_req = 1'b1;
        if (with_pause && sent == count / 2) begin
          drop_valid(0);
          while (sb.outstanding() != 0) @(posedge clk_i);
        end
      end
      if (!steady) drop_valid($urandom_range(0, 8));
    end
  endtask

  // Stimulus and end of run
  initial begin
    logic [14:0] settings[7];
    settings = '{15'd16383, 15'd0, 15'd16384, 15'd15000, 15'd32767, 15'd0, 15'd16383};
    settings[5] = 15'($urandom_range(12000, 16384));
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_linear_threshold_i = '0;
    in_valid_i = 1'b0;
    {first_x_i, first_y_i, first_z_i, first_w_i} = '0;
    {second_x_i, second_y_i, second_z_i, second_w_i} = '0;
    blend_factor_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (settings[p]) begin
      drain();
      write_threshold(settings[p]);
      if (p == 0) run_directed();
      run_random(200, p == 3, p == 1, p == 2);
    end

    drop_valid(0);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
